// File: src/dilt_pkg.sv
`timescale 1ns / 1ps

package dilt_pkg;

    localparam int VALUE_BITS_DEF  = 64;
    localparam int NUMBER_W        = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int BYTE_W          = 8;
    localparam int DIGIT_W         = 4;

    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [DIGIT_W-1:0] TEN     = 4'd10;

    typedef enum logic [2:0] {
        K_LIST_END,
        K_DELIM,
        K_LEAD,
        K_PLUS,
        K_MINUS,
        K_DIGIT,
        K_OTHER
    } t_kind;

    typedef enum logic [2:0] {
        PH_EMPTY,
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_BAD
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
    } t_tok_item;

endpackage

// File: src/decimal_id_list_tokenizer_top.sv
// A byte is held in the queue, and the result it causes in the output register.
// Throughput: one byte per cycle while the output accepts results; the
// multiply-by-ten add and limit compare are combinational, so the queue
// drains at full rate. A stalled output fills the queue, after which
// o_s_tready drops. Reset (i_rst_n low, synchronous) empties the queue,
// clears the token state and drops o_m_tvalid.
`timescale 1ns / 1ps

module decimal_id_list_tokenizer_top
    import dilt_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [BYTE_W-1:0]   i_s_tdata,   // [7:0] text_byte
    input  logic                i_s_tuser,   // [0] action
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [NUMBER_W-1:0] o_m_tdata,   // [63:0] number
    output logic                o_m_tuser,   // [0] has_number
    output logic                o_m_tlast
);

    logic      q_full;
    logic      q_push;
    t_tok_item q_in;
    logic      q_valid;
    t_tok_item q_out;
    logic      q_pop;

    dilt_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_item     (q_in)
    );

    dilt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    dilt_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_out),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: src/dilt_front.sv
`timescale 1ns / 1ps

module dilt_front
    import dilt_pkg::*;
(
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_q_full,
    output logic              o_push,
    output t_tok_item         o_item
);

    t_kind kind;

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        if (i_s_tuser) begin
            kind = K_LIST_END;
        end else if (i_s_tdata == CH_COMMA || i_s_tdata == CH_SEMI ||
                     i_s_tdata == CH_SPACE || i_s_tdata == CH_TAB ||
                     i_s_tdata == CH_LF || i_s_tdata == CH_CR) begin
            kind = K_DELIM;
        end else if (i_s_tdata == CH_VT || i_s_tdata == CH_FF) begin
            kind = K_LEAD;
        end else if (i_s_tdata == CH_PLUS) begin
            kind = K_PLUS;
        end else if (i_s_tdata == CH_MINUS) begin
            kind = K_MINUS;
        end else if (i_s_tdata >= CH_0 && i_s_tdata <= CH_9) begin
            kind = K_DIGIT;
        end else begin
            kind = K_OTHER;
        end
    end

    assign o_item.kind  = kind;
    assign o_item.digit = i_s_tdata[DIGIT_W-1:0];

endmodule

// File: src/dilt_queue.sv
`timescale 1ns / 1ps

module dilt_queue
    import dilt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_tok_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_tok_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tok_item         r_mem [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     n_wr;
    logic [PW-1:0]     n_rd;
    logic [CW-1:0]     n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: src/dilt_back.sv
`timescale 1ns / 1ps

module dilt_back
    import dilt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_tok_item           i_q_item,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [NUMBER_W-1:0] o_m_tdata,
    output logic                o_m_tuser,
    output logic                o_m_tlast
);

    localparam int WW = VALUE_BITS + 4;

    t_phase                   r_phase;
    t_phase                   n_phase;
    logic [VALUE_BITS-1:0]    r_mag;
    logic [VALUE_BITS-1:0]    n_mag;
    logic                     r_neg;
    logic                     n_neg;

    logic                     r_out_valid;
    logic [NUMBER_W-1:0]      r_out_num;
    logic                     r_out_has;
    logic                     r_out_last;

    logic [WW-1:0]            mag_next;
    logic [WW-1:0]            mag_lim;
    logic                     over;
    logic                     tok_ok;
    logic                     emit;
    logic                     out_free;
    logic signed [VALUE_BITS-1:0] s_val;
    logic [NUMBER_W-1:0]      res_num;

    // multiply by ten as two shifted copies, then add the digit
    assign mag_next = WW'({r_mag, 3'b000}) + WW'({r_mag, 1'b0}) + WW'(i_q_item.digit);
    assign mag_lim  = (WW'(1) << (VALUE_BITS - 1)) - WW'(!r_neg);
    assign over     = (mag_next > mag_lim);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_neg   = r_neg;
        if (i_q_item.kind == K_LIST_END || i_q_item.kind == K_DELIM) begin
            n_phase = PH_EMPTY;
            n_mag   = '0;
            n_neg   = 1'b0;
        end else begin
            case (r_phase)
                PH_EMPTY, PH_LEAD: begin
                    case (i_q_item.kind)
                        K_LEAD: begin
                            n_phase = PH_LEAD;
                        end
                        K_PLUS: begin
                            n_neg   = 1'b0;
                            n_phase = PH_SIGN;
                        end
                        K_MINUS: begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end
                        K_DIGIT: begin
                            if (over) begin
                                n_phase = PH_BAD;
                            end else begin
                                n_phase = PH_DIGITS;
                                n_mag   = mag_next[VALUE_BITS-1:0];
                            end
                        end
                        default: begin
                            n_phase = PH_BAD;
                        end
                    endcase
                end
                PH_SIGN, PH_DIGITS: begin
                    if (i_q_item.kind == K_DIGIT && !over) begin
                        n_phase = PH_DIGITS;
                        n_mag   = mag_next[VALUE_BITS-1:0];
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        tok_ok  = (r_phase == PH_DIGITS) && (r_mag != '0);
        s_val   = r_neg ? -r_mag : r_mag;
        res_num = tok_ok ? NUMBER_W'(s_val) : '0;
        emit    = (i_q_item.kind == K_LIST_END) || (i_q_item.kind == K_DELIM && tok_ok);
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign o_pop    = i_q_valid && (!emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_EMPTY;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
            end
            if (out_free) begin
                r_out_valid <= o_pop && emit;
            end
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_num  <= res_num;
            r_out_has  <= tok_ok;
            r_out_last <= (i_q_item.kind == K_LIST_END);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_num;
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_last;

endmodule

// File: src/dilt_checker.sv
`timescale 1ns / 1ps

module dilt_checker
    import dilt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [NUMBER_W-1:0] o_m_tdata,
    input logic                o_m_tuser,
    input logic                o_m_tlast
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    a_zero_without_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0 && o_m_tlast)
        else $error("result without value is not an empty list end");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata != '0)
        else $error("value result carries zero");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind decimal_id_list_tokenizer_top dilt_checker u_dilt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: bench/tb_decimal_id_list_tokenizer_top.sv
`timescale 1ns / 1ps

module tb_decimal_id_list_tokenizer_top;
    import dilt_pkg::*;

    typedef struct packed {
        logic              act;
        logic [BYTE_W-1:0] ch;
    } t_list_item;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                has_number;
        logic                list_end;
    } t_token_result;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [NUMBER_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    t_list_item    text_q[$];
    t_token_result token_q[$];

    logic [NUMBER_W-1:0] tok_mag = '0;
    logic                tok_neg = 1'b0;
    t_phase              tok_phase = PH_EMPTY;

    logic s_acc = 1'b0;
    logic m_acc = 1'b0;
    int   in_count = 0;
    int   out_count = 0;
    int   number_count = 0;
    int   end_count = 0;
    int   mismatches = 0;
    int   total_items = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic hold_active;

    decimal_id_list_tokenizer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [7:0] text_byte
        .i_s_tuser  (s_tuser),   // [0] action
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [63:0] number
        .o_m_tuser  (m_tuser),   // [0] has_number
        .o_m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic t_token_result token_flush();
        t_token_result r;
        logic          ok;
        ok = (tok_phase == PH_DIGITS) && (tok_mag != '0);
        r.number     = ok ? (tok_neg ? -tok_mag : tok_mag) : '0;
        r.has_number = ok;
        r.list_end   = 1'b0;
        tok_mag   = '0;
        tok_neg   = 1'b0;
        tok_phase = PH_EMPTY;
        return r;
    endfunction

    function automatic void tokenizer_predict(input logic act, input logic [BYTE_W-1:0] c,
                                              output logic fire, output t_token_result r);
        logic [NUMBER_W-1:0] lim;
        logic [NUMBER_W-1:0] d;
        logic                is_dig;
        logic                is_del;
        logic                at_start;
        fire = 1'b0;
        r = '0;
        is_dig = (c >= CH_0) && (c <= CH_9);
        is_del = (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_SPACE) ||
                 (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        at_start = (tok_phase == PH_EMPTY) || (tok_phase == PH_LEAD);
        if (act) begin
            r = token_flush();
            r.list_end = 1'b1;
            fire = 1'b1;
        end else if (is_del) begin
            if (tok_phase != PH_EMPTY) begin
                r = token_flush();
                fire = r.has_number;
            end
        end else if (at_start && (c == CH_VT || c == CH_FF)) begin
            tok_phase = PH_LEAD;
        end else if (at_start && (c == CH_PLUS || c == CH_MINUS)) begin
            tok_neg = (c == CH_MINUS);
            tok_phase = PH_SIGN;
        end else if (tok_phase != PH_BAD && is_dig) begin
            lim = (64'd1 << (VALUE_BITS_DEF - 1)) - {63'd0, !tok_neg};
            d = {{(NUMBER_W-BYTE_W){1'b0}}, c - CH_0};
            if (tok_mag > (lim - d) / 10) begin
                tok_phase = PH_BAD;
            end else begin
                tok_mag = tok_mag * 10 + d;
                tok_phase = PH_DIGITS;
            end
        end else begin
            tok_phase = PH_BAD;
        end
    endfunction

    task automatic add_byte(input logic act, input logic [BYTE_W-1:0] c);
        text_q.insert(text_q.size(), t_list_item'{act, c});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(1'b0, s[i]);
    endtask

    function automatic logic [BYTE_W-1:0] pick_delim();
        case ($urandom_range(0, 5))
            0: return CH_COMMA;
            1: return CH_SEMI;
            2: return CH_SPACE;
            3: return CH_TAB;
            4: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic add_extreme_token();
        case ($urandom_range(0, 5))
            0: add_text("9223372036854775807");
            1: add_text("9223372036854775808");
            2: add_text("-9223372036854775808");
            3: add_text("-9223372036854775809");
            4: add_text("+0000000000000000000000001");
            default: add_text("99999999999999999999");
        endcase
    endtask

    task automatic add_random_token(input logic broken);
        logic [BYTE_W-1:0] tok[$];
        int                n;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2))
                tok.insert(tok.size(), $urandom_range(0, 1) ? CH_VT : CH_FF);
        end
        case ($urandom_range(0, 3))
            0: tok.insert(tok.size(), CH_PLUS);
            1: tok.insert(tok.size(), CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 19);
        repeat (n) tok.insert(tok.size(), BYTE_W'(CH_0 + $urandom_range(0, 9)));
        if (broken) tok.insert($urandom_range(0, tok.size()), BYTE_W'($urandom_range(0, 255)));
        foreach (tok[i]) add_byte(1'b0, tok[i]);
    endtask

    task automatic note_mismatch(input string what, input t_token_result want,
                                 input t_token_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("mismatch (%s): expected number=%0d has_number=%0b list_end=%0b, ",
                   what, $signed(want.number), want.has_number, want.list_end);
            $display("got number=%0d has_number=%0b list_end=%0b",
                     $signed(got.number), got.has_number, got.list_end);
        end
    endtask

    always @(posedge clk) begin
        logic          fire;
        t_token_result r;
        t_token_result got;
        s_acc <= rst_n && s_tvalid && s_tready;
        m_acc <= rst_n && m_tvalid && m_tready;
        if (rst_n && s_tvalid && s_tready) begin
            tokenizer_predict(s_tuser, s_tdata, fire, r);
            if (fire) token_q.insert(token_q.size(), r);
            in_count++;
        end
        if (rst_n && m_tvalid && m_tready) begin
            got = '{number: m_tdata, has_number: m_tuser, list_end: m_tlast};
            out_count++;
            if (m_tuser) number_count++;
            if (m_tlast) end_count++;
            if (token_q.size() == 0) begin
                note_mismatch("unexpected transaction", '0, got);
            end else begin
                r = token_q.pop_front();
                if (got !== r) note_mismatch("field", r, got);
            end
        end
    end

    // sender: hold the item until accepted, then wait a drawn gap
    always @(negedge clk) begin
        t_list_item item;
        static int   tx_wait = 0;
        static logic tx_fast = 1'b0;
        if (rst_n && (!s_tvalid || s_acc)) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (text_q.size() > 0) begin
                item = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= item.ch;
                s_tuser <= item.act;
                if ($urandom_range(0, 39) == 0) tx_fast = !tx_fast;
                tx_wait = tx_fast ? 0 : $urandom_range(0, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall a drawn number of cycles after each transaction
    always @(negedge clk) begin
        static int   rx_wait = 0;
        static logic rx_fast = 1'b0;
        if (rst_n) begin
            if (m_acc) begin
                if ($urandom_range(0, 19) == 0) rx_fast = !rx_fast;
                rx_wait = rx_fast ? 0 : $urandom_range(0, 15);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !hold_active;
            end
        end
    end

    assign hold_active = (hold_left > 0);

    // long output stall once the stream is well under way
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (!hold_done && in_count >= 120) begin
                hold_left <= 300;
                hold_done <= 1'b1;
            end
        end
    end

    initial begin
        int choice;
        add_text("0,");
        add_text("-0;");
        add_byte(1'b0, CH_VT);
        add_byte(1'b0, CH_FF);
        add_text("+7 ");
        add_text("--1");
        add_byte(1'b0, CH_TAB);
        add_byte(1'b0, 8'hFF);
        add_byte(1'b0, CH_LF);
        add_byte(1'b0, 8'h00);
        add_byte(1'b0, CH_CR);
        add_text(",,+,");
        add_byte(1'b0, CH_VT);
        add_text(";5");
        add_byte(1'b1, 8'h00);
        add_byte(1'b1, BYTE_W'($urandom_range(0, 255)));
        while (text_q.size() < 530) begin
            choice = $urandom_range(0, 99);
            if (choice < 55) begin
                add_random_token(1'b0);
                add_byte(1'b0, pick_delim());
            end else if (choice < 63) begin
                add_extreme_token();
                add_byte(1'b0, pick_delim());
            end else if (choice < 75) begin
                add_random_token(1'b1);
                add_byte(1'b0, pick_delim());
            end else if (choice < 85) begin
                repeat ($urandom_range(1, 4)) add_byte(1'b0, BYTE_W'($urandom_range(0, 255)));
            end else if (choice < 92) begin
                add_byte(1'b1, BYTE_W'($urandom_range(0, 255)));
            end else begin
                add_random_token(1'b0);
                add_byte(1'b1, BYTE_W'($urandom_range(0, 255)));
            end
        end
        add_byte(1'b1, 8'h00);
        total_items = text_q.size();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        wait (in_count == total_items);
        wait (token_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("sent %0d list bytes and end marks, including one long output stall",
                 in_count);
        $display("checked %0d results: %0d numbers, %0d list ends, %0d mismatches",
                 out_count, number_count, end_count, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout: %0d of %0d items accepted, %0d results pending",
                 in_count, total_items, token_q.size());
        $display("status: fail");
        $finish;
    end

endmodule

// File: decimal_id_list_tokenizer_top.f
src/dilt_pkg.sv
src/dilt_front.sv
src/dilt_queue.sv
src/dilt_back.sv
src/decimal_id_list_tokenizer_top.sv
src/dilt_checker.sv
bench/tb_decimal_id_list_tokenizer_top.sv
